// ===== sv/tps_pkg.sv =====
`default_nettype none
package tps_pkg;

    typedef struct packed {
        logic               operation;
        logic [5:0]         entry_index;
        logic signed [31:0] x_value;
        logic signed [31:0] y_value;
        logic signed [31:0] weight_x_in;
        logic signed [31:0] weight_y_in;
        logic               last_point;
    } tps_in_t;

    typedef struct packed {
        logic signed [31:0] x_out;
        logic signed [31:0] y_out;
        logic               last_out;
    } tps_out_t;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_AFF_XX  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AFF_XY  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AFF_X0  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AFF_YX  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AFF_YY  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_AFF_Y0  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT   = 4'd7;

    // ln2 in Q1.30
    localparam logic [30:0] LN2_Q30 = 31'd744261118;

    typedef enum logic [4:0] {
        ST_IDLE, ST_AX0, ST_AX1, ST_AX2, ST_AY1, ST_AY2,
        ST_RD, ST_DX, ST_DY, ST_RS, ST_NORM,
        ST_LUT, ST_LG, ST_LN, ST_KH, ST_KR, ST_KL, ST_KS,
        ST_WX, ST_WXL, ST_WXS, ST_WYL, ST_WYS, ST_DONE
    } tps_state_t;

    // log2(1 + i/64) in Q1.16
    function automatic logic [16:0] frac_log2(input logic [5:0] i);
        logic [16:0] v;
        begin
            case (i)
                6'd0:  v = 17'd0;     6'd1:  v = 17'd1466;  6'd2:  v = 17'd2909;
                6'd3:  v = 17'd4331;  6'd4:  v = 17'd5732;  6'd5:  v = 17'd7112;
                6'd6:  v = 17'd8473;  6'd7:  v = 17'd9814;  6'd8:  v = 17'd11136;
                6'd9:  v = 17'd12440; 6'd10: v = 17'd13727; 6'd11: v = 17'd14996;
                6'd12: v = 17'd16248; 6'd13: v = 17'd17484; 6'd14: v = 17'd18704;
                6'd15: v = 17'd19909; 6'd16: v = 17'd21098; 6'd17: v = 17'd22272;
                6'd18: v = 17'd23433; 6'd19: v = 17'd24579; 6'd20: v = 17'd25711;
                6'd21: v = 17'd26830; 6'd22: v = 17'd27936; 6'd23: v = 17'd29029;
                6'd24: v = 17'd30109; 6'd25: v = 17'd31178; 6'd26: v = 17'd32234;
                6'd27: v = 17'd33279; 6'd28: v = 17'd34312; 6'd29: v = 17'd35334;
                6'd30: v = 17'd36346; 6'd31: v = 17'd37346; 6'd32: v = 17'd38336;
                6'd33: v = 17'd39316; 6'd34: v = 17'd40286; 6'd35: v = 17'd41246;
                6'd36: v = 17'd42196; 6'd37: v = 17'd43137; 6'd38: v = 17'd44068;
                6'd39: v = 17'd44990; 6'd40: v = 17'd45904; 6'd41: v = 17'd46809;
                6'd42: v = 17'd47705; 6'd43: v = 17'd48593; 6'd44: v = 17'd49472;
                6'd45: v = 17'd50344; 6'd46: v = 17'd51207; 6'd47: v = 17'd52063;
                6'd48: v = 17'd52911; 6'd49: v = 17'd53751; 6'd50: v = 17'd54584;
                6'd51: v = 17'd55410; 6'd52: v = 17'd56229; 6'd53: v = 17'd57040;
                6'd54: v = 17'd57845; 6'd55: v = 17'd58643; 6'd56: v = 17'd59434;
                6'd57: v = 17'd60219; 6'd58: v = 17'd60997; 6'd59: v = 17'd61769;
                6'd60: v = 17'd62534; 6'd61: v = 17'd63294; 6'd62: v = 17'd64047;
                default: v = 17'd64794;
            endcase
            return v;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        begin
            if (v > 68'sh0_0000_0000_7FFF_FFFF)
                r = 32'sh7FFF_FFFF;
            else if (v < -68'sh0_0000_0000_8000_0000)
                r = 32'sh8000_0000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ===== sv/tps_mul.sv =====
`default_nettype none
// shared signed multiplier, product registered
module tps_mul (
    input  wire logic               clk,
    input  wire logic signed [33:0] a,
    input  wire logic signed [33:0] b,
    output logic signed [67:0]      prod
);

    logic signed [67:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

// ===== sv/thin_plate_spline_eval.sv =====
`default_nettype none
// Load item: accepted with no result; the input is ready again the next cycle.
// Evaluate item: after acceptance, the affine steps, then per active center RD, DX,
// DY, RS and, for r2 above the threshold, NORM through WYS, then DONE during any
// output stall; no new item is taken until the input reopens with the result.
// Reset (async, active low) restores config and control registers to defaults;
// datapath registers are not reset; center memories hold garbage until loaded.
module thin_plate_spline_eval #(
    parameter int MAX_CENTERS = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire tps_pkg::tps_in_t              in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output tps_pkg::tps_out_t                  out_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [tps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                   cfg_data
);

    localparam int AW = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int CW = $clog2(MAX_CENTERS + 1);
    localparam int IW = (AW > 6) ? AW : 6;
    localparam logic [30:0] LN2_Q30_W = tps_pkg::LN2_Q30;

    // configuration
    logic signed [31:0] aff_xx_reg, aff_xy_reg, aff_x0_reg;
    logic signed [31:0] aff_yx_reg, aff_yy_reg, aff_y0_reg;
    logic [30:0]        thresh_reg;
    logic [6:0]         count_reg;

    // center memories
    logic signed [31:0] center_x [MAX_CENTERS];
    logic signed [31:0] center_y [MAX_CENTERS];
    logic signed [31:0] weight_x [MAX_CENTERS];
    logic signed [31:0] weight_y [MAX_CENTERS];
    logic signed [31:0] cx_q, cy_q, wx_q, wy_q;

    tps_pkg::tps_state_t state_reg, state_next;
    logic [CW-1:0]       j_reg;
    logic [CW-1:0]       n_eff;
    logic                last_center;

    logic signed [31:0] x_reg, y_reg;
    logic               last_reg;
    logic signed [67:0] sum_reg;
    logic signed [63:0] accx_reg, accy_reg;
    logic [48:0]        r_reg, norm_reg;
    logic [5:0]         sh_reg;
    logic [2:0]         step_reg;
    logic signed [23:0] l_reg, lnq_reg;
    logic signed [63:0] k_reg;

    logic                out_valid_reg;
    tps_pkg::tps_out_t   out_data_reg;

    logic signed [33:0] ma, mb;
    logic signed [67:0] prod;

    logic               in_accept;
    logic [IW-1:0]      slot_w;
    logic               slot_ok;
    logic [AW-1:0]      waddr;

    logic signed [32:0] dx, dy;
    logic [67:0]        rsum;
    logic [48:0]        rcalc;
    logic               skip;
    logic [5:0]         shamt;
    logic               top_zero;
    logic [5:0]         lidx;
    logic [16:0]        lo_v, hi_v, diff;
    logic signed [7:0]  pm16;
    logic signed [23:0] lcalc;
    logic               ksat;
    logic signed [31:0] wsel;
    logic signed [67:0] texact;
    logic signed [31:0] term;
    logic               out_free;

    tps_mul u_mul (
        .clk  (clk),
        .a    (ma),
        .b    (mb),
        .prod (prod)
    );

    assign in_stall  = (state_reg != tps_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign slot_w  = IW'(in_data.entry_index);
    assign slot_ok = (32'(slot_w) < MAX_CENTERS);
    assign waddr   = slot_w[AW-1:0];

    assign n_eff = (32'(count_reg) > MAX_CENTERS) ? CW'(MAX_CENTERS) : CW'(count_reg);
    assign last_center = (({1'b0, j_reg} + 1'b1) >= {1'b0, n_eff});

    assign dx = {x_reg[31], x_reg} - {cx_q[31], cx_q};
    assign dy = {y_reg[31], y_reg} - {cy_q[31], cy_q};

    // r2 in Q16.16: both squares are nonnegative
    assign rsum  = 68'(sum_reg) + 68'(prod);
    assign rcalc = rsum[64:16];
    assign skip  = (rcalc <= {18'd0, thresh_reg});

    // leading-one search, 32/16/8/4/2/1 bit steps
    assign shamt    = 6'd32 >> step_reg;
    assign top_zero = ((norm_reg >> (6'd49 - shamt)) == '0);

    assign lidx = norm_reg[47:42];
    assign lo_v = tps_pkg::frac_log2(lidx);
    assign hi_v = (lidx == 6'd63) ? 17'd65536 : tps_pkg::frac_log2(lidx + 6'd1);
    assign diff = hi_v - lo_v;
    assign pm16 = 8'sd32 - $signed({2'b00, sh_reg});
    assign lcalc = $signed({pm16, 16'd0}) + $signed({7'd0, lo_v})
                 + $signed({7'd0, prod[32:16]});

    // K outside 33-bit high part saturates any nonzero weight
    assign ksat   = (k_reg[63:48] != {16{k_reg[48]}});
    assign wsel   = (state_reg == tps_pkg::ST_WXS) ? wx_q : wy_q;
    assign texact = sum_reg + (prod >>> 16);

    always_comb
    begin
        if (ksat) begin
            if (wsel == '0)
                term = '0;
            else if (wsel[31] ^ k_reg[63])
                term = 32'sh8000_0000;
            else
                term = 32'sh7FFF_FFFF;
        end
        else begin
            term = tps_pkg::sat32(texact);
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (in_accept && (in_data.operation == tps_pkg::OP_LOAD) && slot_ok) begin
            center_x[waddr] <= in_data.x_value;
            center_y[waddr] <= in_data.y_value;
            weight_x[waddr] <= in_data.weight_x_in;
            weight_y[waddr] <= in_data.weight_y_in;
        end
        cx_q <= center_x[j_reg[AW-1:0]];
        cy_q <= center_y[j_reg[AW-1:0]];
        wx_q <= weight_x[j_reg[AW-1:0]];
        wy_q <= weight_y[j_reg[AW-1:0]];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            aff_xx_reg <= 32'sd65536;
            aff_xy_reg <= '0;
            aff_x0_reg <= '0;
            aff_yx_reg <= '0;
            aff_yy_reg <= 32'sd65536;
            aff_y0_reg <= '0;
            thresh_reg <= 31'd1;
            count_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                tps_pkg::CFG_AFF_XX: aff_xx_reg <= cfg_data;
                tps_pkg::CFG_AFF_XY: aff_xy_reg <= cfg_data;
                tps_pkg::CFG_AFF_X0: aff_x0_reg <= cfg_data;
                tps_pkg::CFG_AFF_YX: aff_yx_reg <= cfg_data;
                tps_pkg::CFG_AFF_YY: aff_yy_reg <= cfg_data;
                tps_pkg::CFG_AFF_Y0: aff_y0_reg <= cfg_data;
                tps_pkg::CFG_THRESH: thresh_reg <= cfg_data[30:0];
                tps_pkg::CFG_COUNT:  count_reg  <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= tps_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ma = '0;
        mb = '0;
        unique case (state_reg)
            tps_pkg::ST_IDLE:
                if (in_accept && (in_data.operation == tps_pkg::OP_EVAL))
                    state_next = tps_pkg::ST_AX0;
            tps_pkg::ST_AX0:
            begin
                ma = 34'(aff_xx_reg); mb = 34'(x_reg);
                state_next = tps_pkg::ST_AX1;
            end
            tps_pkg::ST_AX1:
            begin
                ma = 34'(aff_xy_reg); mb = 34'(y_reg);
                state_next = tps_pkg::ST_AX2;
            end
            tps_pkg::ST_AX2:
            begin
                ma = 34'(aff_yx_reg); mb = 34'(x_reg);
                state_next = tps_pkg::ST_AY1;
            end
            tps_pkg::ST_AY1:
            begin
                ma = 34'(aff_yy_reg); mb = 34'(y_reg);
                state_next = tps_pkg::ST_AY2;
            end
            tps_pkg::ST_AY2:
                state_next = (n_eff == '0) ? tps_pkg::ST_DONE : tps_pkg::ST_RD;
            tps_pkg::ST_RD:
                state_next = tps_pkg::ST_DX;
            tps_pkg::ST_DX:
            begin
                ma = 34'(dx); mb = 34'(dx);
                state_next = tps_pkg::ST_DY;
            end
            tps_pkg::ST_DY:
            begin
                ma = 34'(dy); mb = 34'(dy);
                state_next = tps_pkg::ST_RS;
            end
            tps_pkg::ST_RS:
                if (skip)
                    state_next = last_center ? tps_pkg::ST_DONE : tps_pkg::ST_RD;
                else
                    state_next = tps_pkg::ST_NORM;
            tps_pkg::ST_NORM:
                if (step_reg == 3'd5)
                    state_next = tps_pkg::ST_LUT;
            tps_pkg::ST_LUT:
            begin
                ma = $signed({17'd0, diff});
                mb = $signed({18'd0, norm_reg[41:26]});
                state_next = tps_pkg::ST_LG;
            end
            tps_pkg::ST_LG:
                state_next = tps_pkg::ST_LN;
            tps_pkg::ST_LN:
            begin
                ma = 34'(l_reg); mb = $signed({3'd0, LN2_Q30_W});
                state_next = tps_pkg::ST_KH;
            end
            tps_pkg::ST_KH:
                state_next = tps_pkg::ST_KR;
            tps_pkg::ST_KR:
            begin
                ma = $signed({1'b0, r_reg[48:16]}); mb = 34'(lnq_reg);
                state_next = tps_pkg::ST_KL;
            end
            tps_pkg::ST_KL:
            begin
                ma = $signed({18'd0, r_reg[15:0]}); mb = 34'(lnq_reg);
                state_next = tps_pkg::ST_KS;
            end
            tps_pkg::ST_KS:
                state_next = tps_pkg::ST_WX;
            tps_pkg::ST_WX:
            begin
                ma = 34'(wx_q); mb = 34'($signed(k_reg[48:16]));
                state_next = tps_pkg::ST_WXL;
            end
            tps_pkg::ST_WXL:
            begin
                ma = 34'(wx_q); mb = $signed({18'd0, k_reg[15:0]});
                state_next = tps_pkg::ST_WXS;
            end
            tps_pkg::ST_WXS:
            begin
                ma = 34'(wy_q); mb = 34'($signed(k_reg[48:16]));
                state_next = tps_pkg::ST_WYL;
            end
            tps_pkg::ST_WYL:
            begin
                ma = 34'(wy_q); mb = $signed({18'd0, k_reg[15:0]});
                state_next = tps_pkg::ST_WYS;
            end
            tps_pkg::ST_WYS:
                state_next = last_center ? tps_pkg::ST_DONE : tps_pkg::ST_RD;
            tps_pkg::ST_DONE:
                if (out_free)
                    state_next = tps_pkg::ST_IDLE;
            default:
                state_next = tps_pkg::ST_IDLE;
        endcase
    end

    // center index and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            j_reg         <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (state_reg == tps_pkg::ST_AY2)
                j_reg <= '0;
            else if (((state_reg == tps_pkg::ST_RS) && skip
                      || (state_reg == tps_pkg::ST_WYS)) && !last_center)
                j_reg <= j_reg + 1'b1;

            if (state_reg == tps_pkg::ST_RS)
                step_reg <= '0;
            else if (state_reg == tps_pkg::ST_NORM)
                step_reg <= step_reg + 3'd1;

            if ((state_reg == tps_pkg::ST_DONE) && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            tps_pkg::ST_IDLE:
                if (in_accept) begin
                    x_reg    <= in_data.x_value;
                    y_reg    <= in_data.y_value;
                    last_reg <= in_data.last_point;
                end
            tps_pkg::ST_AX1, tps_pkg::ST_AY1, tps_pkg::ST_DY, tps_pkg::ST_KL,
            tps_pkg::ST_WXL, tps_pkg::ST_WYL:
                sum_reg <= prod;
            tps_pkg::ST_AX2:
                accx_reg <= 64'((sum_reg + prod) >>> 16) + 64'(aff_x0_reg);
            tps_pkg::ST_AY2:
                accy_reg <= 64'((sum_reg + prod) >>> 16) + 64'(aff_y0_reg);
            tps_pkg::ST_RS:
            begin
                r_reg    <= rcalc;
                norm_reg <= rcalc;
                sh_reg   <= '0;
            end
            tps_pkg::ST_NORM:
                if (top_zero) begin
                    norm_reg <= norm_reg << shamt;
                    sh_reg   <= sh_reg + shamt;
                end
            tps_pkg::ST_LG:
                l_reg <= lcalc;
            tps_pkg::ST_KH:
                lnq_reg <= prod[53:30];
            tps_pkg::ST_KS:
                k_reg <= 64'(sum_reg + (prod >>> 16));
            tps_pkg::ST_WXS:
                accx_reg <= accx_reg + 64'(term);
            tps_pkg::ST_WYS:
                accy_reg <= accy_reg + 64'(term);
            tps_pkg::ST_DONE:
                if (out_free) begin
                    out_data_reg.x_out    <= tps_pkg::sat32(68'(accx_reg));
                    out_data_reg.y_out    <= tps_pkg::sat32(68'(accy_reg));
                    out_data_reg.last_out <= last_reg;
                end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/tps_chk.sv =====
`default_nettype none
module tps_chk (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_stall,
    input wire tps_pkg::tps_in_t  in_data,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire tps_pkg::tps_out_t out_data
);

    // an evaluate keeps the block busy on the next cycle
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (in_data.operation == tps_pkg::OP_EVAL) |=> in_stall)
        else $error("evaluate item did not occupy the block");

    // a load leaves the input ready on the next cycle
    a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (in_data.operation == tps_pkg::OP_LOAD) |=> !in_stall)
        else $error("load item stalled the input");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("stalled result dropped");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("stalled result changed");

endmodule

bind thin_plate_spline_eval tps_chk u_tps_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
`default_nettype wire

// ===== tb/thin_plate_spline_eval_tb.sv =====
`timescale 1ns / 100ps
module thin_plate_spline_eval_tb;

    localparam int NUM_CENTERS = 64;
    localparam longint CYCLE_LIMIT = 64'd4000000;
    localparam logic [tps_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 4'd9;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    tps_pkg::tps_in_t in_data;
    logic out_valid;
    logic out_stall;
    tps_pkg::tps_out_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [tps_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    thin_plate_spline_eval dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // shadow of the block's registers and center memory
    logic signed [31:0] gain_xx, gain_xy, off_x, gain_yx, gain_yy, off_y;
    logic [30:0] skip_r2;
    logic [6:0] active_count;
    logic signed [31:0] cen_x [NUM_CENTERS];
    logic signed [31:0] cen_y [NUM_CENTERS];
    logic signed [31:0] wgt_x [NUM_CENTERS];
    logic signed [31:0] wgt_y [NUM_CENTERS];

    tps_pkg::tps_out_t mapped_q[$];
    int errors;
    bit quiet;
    longint cycles;

    localparam int LOG_TAB [65] = '{
        0, 1466, 2909, 4331, 5732, 7112, 8473, 9814,
        11136, 12440, 13727, 14996, 16248, 17484, 18704, 19909,
        21098, 22272, 23433, 24579, 25711, 26830, 27936, 29029,
        30109, 31178, 32234, 33279, 34312, 35334, 36346, 37346,
        38336, 39316, 40286, 41246, 42196, 43137, 44068, 44990,
        45904, 46809, 47705, 48593, 49472, 50344, 51207, 52063,
        52911, 53751, 54584, 55410, 56229, 57040, 57845, 58643,
        59434, 60219, 60997, 61769, 62534, 63294, 64047, 64794, 65536
    };

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // r2 * ln(r2) in Q16.16, from r2 in raw Q16.16 units
    function automatic logic signed [127:0] r2_log_r2(input logic [63:0] r);
        int p;
        logic [63:0] frac;
        logic signed [127:0] lo_v, hi_v, l, lnq, rem;
        p = 48;
        while (p > 0 && r[p] == 1'b0)
            p--;
        frac = (r << (48 - p)) & 64'hFFFF_FFFF_FFFF;
        lo_v = 128'(LOG_TAB[frac[47:42]]);
        hi_v = 128'(LOG_TAB[frac[47:42] + 1]);
        rem = 128'(frac[41:26]);
        l = 128'(p - 16) * 128'sd65536 + lo_v + (((hi_v - lo_v) * rem) >>> 16);
        lnq = (l * 128'sd744261118) >>> 30;
        return ($signed({64'd0, r}) * lnq) >>> 16;
    endfunction

    function automatic logic signed [127:0] clip32(input logic signed [127:0] v);
        if (v > 128'sd2147483647)
            return 128'sd2147483647;
        if (v < -128'sd2147483648)
            return -128'sd2147483648;
        return v;
    endfunction

    function automatic tps_pkg::tps_out_t map_point(input tps_pkg::tps_in_t it);
        tps_pkg::tps_out_t res;
        logic signed [127:0] ax, ay, dx, dy, k;
        logic [63:0] r;
        int n;
        ax = ((gain_xx * 128'sd1 * it.x_value + gain_xy * 128'sd1 * it.y_value) >>> 16)
            + off_x;
        ay = ((gain_yx * 128'sd1 * it.x_value + gain_yy * 128'sd1 * it.y_value) >>> 16)
            + off_y;
        n = (active_count > NUM_CENTERS) ? NUM_CENTERS : int'(active_count);
        for (int j = 0; j < n; j++)
        begin
            dx = it.x_value - 128'sd0 - cen_x[j];
            dy = it.y_value - 128'sd0 - cen_y[j];
            r = 64'((dx * dx + dy * dy) >>> 16);
            if (r <= 64'(skip_r2) || r == 0)
                continue;
            k = r2_log_r2(r);
            ax += clip32((wgt_x[j] * k) >>> 16);
            ay += clip32((wgt_y[j] * k) >>> 16);
        end
        res.x_out = 32'(clip32(ax));
        res.y_out = 32'(clip32(ay));
        res.last_out = it.last_point;
        return res;
    endfunction

    task automatic write_reg(input logic [tps_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        in_valid <= 1'b0;
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            tps_pkg::CFG_AFF_XX: gain_xx = val;
            tps_pkg::CFG_AFF_XY: gain_xy = val;
            tps_pkg::CFG_AFF_X0: off_x = val;
            tps_pkg::CFG_AFF_YX: gain_yx = val;
            tps_pkg::CFG_AFF_YY: gain_yy = val;
            tps_pkg::CFG_AFF_Y0: off_y = val;
            tps_pkg::CFG_THRESH: skip_r2 = val[30:0];
            tps_pkg::CFG_COUNT: active_count = val[6:0];
            default: ;
        endcase
    endtask

    // valid stays high after acceptance so items can follow back to back
    task automatic send_item(input tps_pkg::tps_in_t it);
        if (!quiet && $urandom_range(99) < 34)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        in_data <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        if (it.operation == tps_pkg::OP_LOAD)
        begin
            cen_x[it.entry_index] = it.x_value;
            cen_y[it.entry_index] = it.y_value;
            wgt_x[it.entry_index] = it.weight_x_in;
            wgt_y[it.entry_index] = it.weight_y_in;
        end
        else
            mapped_q.push_back(map_point(it));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (mapped_q.size() != 0)
            @(posedge clk);
        // settle before the next register write
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [31:0] rnd_val();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return $signed($urandom_range(2000000)) - 1000000;
        endcase
    endfunction

    task automatic load_center(input int j, input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] wx, input logic [31:0] wy);
        tps_pkg::tps_in_t it;
        it = '{operation: tps_pkg::OP_LOAD, entry_index: j[5:0], x_value: x, y_value: y,
               weight_x_in: wx, weight_y_in: wy, last_point: 1'($urandom_range(1))};
        send_item(it);
    endtask

    task automatic eval_point(input logic [31:0] x, input logic [31:0] y, input logic last);
        tps_pkg::tps_in_t it;
        it = '{operation: tps_pkg::OP_EVAL, entry_index: 6'($urandom), x_value: x,
               y_value: y, weight_x_in: $urandom, weight_y_in: $urandom, last_point: last};
        send_item(it);
    endtask

    task automatic test_affine_only();
        eval_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        eval_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        eval_point(32'h0, 32'h0, 1'b1);
        drain();
        write_reg(tps_pkg::CFG_AFF_XX, 32'h7FFF_FFFF);
        write_reg(tps_pkg::CFG_AFF_XY, 32'h8000_0000);
        write_reg(tps_pkg::CFG_AFF_X0, 32'h7FFF_FFFF);
        write_reg(tps_pkg::CFG_AFF_YX, 32'h8000_0000);
        write_reg(tps_pkg::CFG_AFF_YY, 32'h7FFF_FFFF);
        write_reg(tps_pkg::CFG_AFF_Y0, 32'h8000_0000);
        eval_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        eval_point(32'hFFFF_FFFF, 32'h0001_0000, 1'b1);
        drain();
    endtask

    task automatic test_kernel_cases();
        for (int j = 0; j < NUM_CENTERS; j++)
            load_center(j, 32'h0, 32'h0, 32'h0001_0000, 32'hFFFF_0000);
        write_reg(tps_pkg::CFG_AFF_XX, 32'h0001_0000);
        write_reg(tps_pkg::CFG_AFF_XY, 32'h0);
        write_reg(tps_pkg::CFG_AFF_X0, 32'h0);
        write_reg(tps_pkg::CFG_AFF_YX, 32'h0);
        write_reg(tps_pkg::CFG_AFF_YY, 32'h0001_0000);
        write_reg(tps_pkg::CFG_AFF_Y0, 32'h0);
        write_reg(tps_pkg::CFG_COUNT, 32'd2);
        write_reg(tps_pkg::CFG_THRESH, 32'd0);
        // r2 zero skipped even with threshold zero; tiny r2 just above it
        eval_point(32'h0, 32'h0, 1'b1);
        eval_point(32'h1, 32'h0, 1'b0);
        eval_point(32'h0000_0100, 32'h0, 1'b1);
        eval_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        drain();
        load_center(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        write_reg(tps_pkg::CFG_THRESH, 32'h7FFF_FFFF);
        eval_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        eval_point(32'h0001_0000, 32'h0, 1'b0);
        drain();
        write_reg(tps_pkg::CFG_THRESH, 32'd1);
        write_reg(tps_pkg::CFG_COUNT, 32'd127);  // above the slot count, clamps
        eval_point(32'h0002_0000, 32'hFFFE_0000, 1'b1);
        drain();
    endtask

    task automatic test_random_maps();
        int n_eval;
        for (int phase = 0; phase < 6; phase++)
        begin
            write_reg(tps_pkg::CFG_AFF_XX, rnd_val());
            write_reg(tps_pkg::CFG_AFF_XY, rnd_val());
            write_reg(tps_pkg::CFG_AFF_X0, rnd_val());
            write_reg(tps_pkg::CFG_AFF_YX, rnd_val());
            write_reg(tps_pkg::CFG_AFF_YY, rnd_val());
            write_reg(tps_pkg::CFG_AFF_Y0, rnd_val());
            write_reg(tps_pkg::CFG_THRESH,
                      $urandom_range(3) == 0 ? $urandom : $urandom_range(70000));
            write_reg(tps_pkg::CFG_COUNT, phase == 5 ? 64 : $urandom_range(8));
            write_reg(CFG_UNUSED, $urandom);  // unused index, no effect
            quiet = (phase == 2);
            for (int i = 0; i < 80; i++)
            begin
                n_eval = (active_count > NUM_CENTERS) ? NUM_CENTERS : int'(active_count);
                if ($urandom_range(3) == 0)
                    load_center($urandom_range(n_eval == 0 ? 63 : n_eval - 1),
                                rnd_val(), rnd_val(), rnd_val(), rnd_val());
                else
                    eval_point(rnd_val(), rnd_val(), 1'($urandom_range(1)));
            end
            drain();
        end
        quiet = 1'b0;
    endtask

    // result checker and output stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (mapped_q.size() == 0)
                begin
                    $error("unexpected result x_out=%0d", out_data.x_out);
                    errors++;
                end
                else
                begin
                    tps_pkg::tps_out_t want;
                    want = mapped_q.pop_front();
                    if (out_data.x_out !== want.x_out)
                    begin
                        $error("x_out expected %0d got %0d", want.x_out, out_data.x_out);
                        errors++;
                    end
                    if (out_data.y_out !== want.y_out)
                    begin
                        $error("y_out expected %0d got %0d", want.y_out, out_data.y_out);
                        errors++;
                    end
                    if (out_data.last_out !== want.last_out)
                    begin
                        $error("last_out expected %0d got %0d", want.last_out,
                               out_data.last_out);
                        errors++;
                    end
                end
            end
            out_stall <= !quiet && ($urandom_range(99) < 34);
        end
    end

    initial
    begin
        errors = 0;
        quiet = 1'b0;
        cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        gain_xx = 32'h0001_0000;
        gain_xy = 0;
        off_x = 0;
        gain_yx = 0;
        gain_yy = 32'h0001_0000;
        off_y = 0;
        skip_r2 = 1;
        active_count = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_affine_only();
        test_kernel_cases();
        test_random_maps();
        if (mapped_q.size() != 0)
        begin
            $error("results still expected: %0d", mapped_q.size());
            errors++;
        end
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ===== files.f =====
sv/tps_pkg.sv
sv/tps_mul.sv
sv/thin_plate_spline_eval.sv
sv/tps_chk.sv
tb/thin_plate_spline_eval_tb.sv
